// File: sv/rau_pkg.sv
// shared types, constants and helper functions of the rational arithmetic unit
package rau_pkg;

    // operand word and port widths
    localparam int WORD_BITS  = 64;
    localparam int IO_BITS    = 64;
    localparam int EXP_BITS   = 32;
    localparam int PROD_BITS  = 2 * WORD_BITS;
    localparam int HALF_BITS  = (WORD_BITS + 1) / 2;
    localparam int PP_BITS    = 2 * HALF_BITS;
    localparam int ACC_BITS   = 4 * HALF_BITS;
    localparam int SHIFT_BITS = $clog2(WORD_BITS);

    // job queue between front and back
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic        [WORD_BITS-1:0] uword_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;

    localparam word_t WORD_MIN  = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});
    localparam word_t WORD_ONE  = word_t'(1);
    localparam word_t WORD_ZERO = word_t'(0);

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4,
        OP_RED = 3'd5,
        OP_POW = 3'd6,
        OP_INV = 3'd7
    } op_t;

    // one classified job as handed from front to back
    typedef struct packed {
        op_t                 op;
        word_t               an;
        word_t               ad;
        word_t               bn;
        word_t               bd;
        logic [EXP_BITS-2:0] expo;
        logic                ov;
    } job_t;

    typedef struct packed {
        word_t n;
        word_t d;
        logic  ov;
    } frac_t;

    // magnitude as an unsigned word, the most negative value included
    function automatic uword_t mag_f(word_t x);
        word_t neg_x;
        neg_x = -x;
        return x[WORD_BITS-1] ? uword_t'(neg_x) : uword_t'(x);
    endfunction

    // make the denominator non-negative by negating both parts
    function automatic frac_t norm_f(word_t n, word_t d);
        frac_t r;
        r.n  = n;
        r.d  = d;
        r.ov = 1'b0;
        if (d[WORD_BITS-1])
        begin
            r.n  = -n;
            r.d  = -d;
            r.ov = (n == WORD_MIN) || (d == WORD_MIN);
        end
        return r;
    endfunction

    // product fits a signed word
    function automatic logic fits_word(prod_t p);
        return (&p[PROD_BITS-1:WORD_BITS-1]) || !(|p[PROD_BITS-1:WORD_BITS-1]);
    endfunction

    // sign-extend a word to port width
    function automatic logic signed [IO_BITS-1:0] to_io(word_t x);
        return IO_BITS'(x);
    endfunction

endpackage

// File: sv/rau_front.sv
// front stage: takes input beats, normalizes the operands and classifies the job
module rau_front
    import rau_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic        [2:0]          action,
    input  logic signed [IO_BITS-1:0]  a_num,
    input  logic signed [IO_BITS-1:0]  a_den,
    input  logic signed [IO_BITS-1:0]  b_num,
    input  logic signed [IO_BITS-1:0]  b_den,
    input  logic signed [EXP_BITS-1:0] exponent,
    output logic                       push,
    output job_t                       push_job,
    input  logic                       q_full
);

    logic  f_valid_reg, f_valid_next;
    job_t  f_job_reg;
    job_t  job_in;
    frac_t fa, fb;
    logic  accept;

    // operand normalization
    always_comb
    begin
        fa = norm_f(word_t'(a_num[WORD_BITS-1:0]), word_t'(a_den[WORD_BITS-1:0]));
        fb = norm_f(word_t'(b_num[WORD_BITS-1:0]), word_t'(b_den[WORD_BITS-1:0]));
        job_in.op   = op_t'(action);
        job_in.an   = fa.n;
        job_in.ad   = fa.d;
        job_in.bn   = fb.n;
        job_in.bd   = fb.d;
        job_in.expo = exponent[EXP_BITS-1] ? '0 : exponent[EXP_BITS-2:0];
        job_in.ov   = fa.ov | fb.ov;
    end

    // handshake with the input side and the queue
    assign in_stall = f_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = f_valid_reg && !q_full;
    assign push_job = f_job_reg;

    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (push)
        begin
            f_valid_next = 1'b0;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_job_reg <= job_in;
        end
    end

endmodule

// File: sv/rau_queue.sv
// short job queue that decouples the front stage from the execution back end
module rau_queue
    import rau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic valid,
    output job_t pop_job
);

    job_t                  mem_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_BITS:0]   count_reg, count_next;
    logic                  do_push, do_pop;

    assign full    = (count_reg == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_job = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_BITS'(Q_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_BITS'(Q_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry write
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: sv/rau_mul.sv
// exact signed word by word multiplier over four half-width partial products
module rau_mul
    import rau_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t x,
    input  word_t y,
    output logic  done,
    output prod_t prod
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic                 pv_reg, pv_next;
    logic [1:0]           psh_reg;
    logic [PP_BITS-1:0]   pp_reg;
    logic [PP_BITS-1:0]   ux_reg, uy_reg;
    logic                 neg_reg;
    logic [ACC_BITS-1:0]  acc_reg;
    prod_t                prod_reg;
    logic [HALF_BITS-1:0] xh, yh;
    logic [PP_BITS-1:0]   pp_now;
    logic [PROD_BITS-1:0] acc_mag;

    // partial product of the selected halves
    always_comb
    begin
        xh      = cnt_reg[1] ? ux_reg[PP_BITS-1:HALF_BITS] : ux_reg[HALF_BITS-1:0];
        yh      = cnt_reg[0] ? uy_reg[PP_BITS-1:HALF_BITS] : uy_reg[HALF_BITS-1:0];
        pp_now  = PP_BITS'(xh) * PP_BITS'(yh);
        acc_mag = acc_reg[PROD_BITS-1:0];
    end

    // sequencing: four products, one add behind each, then the sign
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        pv_next   = 1'b0;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            pv_next  = (cnt_reg < 3'd4);
            if (cnt_reg == 3'd5)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            pv_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            pv_reg   <= pv_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ux_reg  <= PP_BITS'(mag_f(x));
            uy_reg  <= PP_BITS'(mag_f(y));
            neg_reg <= x[WORD_BITS-1] ^ y[WORD_BITS-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < 3'd4)
            begin
                pp_reg  <= pp_now;
                psh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (pv_reg)
            begin
                acc_reg <= acc_reg + (ACC_BITS'(pp_reg) << (HALF_BITS * psh_reg));
            end
            if (cnt_reg == 3'd5)
            begin
                prod_reg <= neg_reg ? prod_t'(-acc_mag) : prod_t'(acc_mag);
            end
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// File: sv/rau_back.sv
// execution back end: product sequencing, binary gcd, restoring divider and result register
module rau_back
    import rau_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_valid,
    input  job_t                      q_job,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [IO_BITS-1:0] res_num,
    output logic signed [IO_BITS-1:0] res_den,
    output logic                      is_equal,
    output logic                      is_less,
    output logic                      is_greater,
    output logic                      overflow,
    output logic                      zero_den
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ARITH = 7'b0000010,
        ST_POWER = 7'b0000100,
        ST_MULW  = 7'b0001000,
        ST_GCD   = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    word_t                 an_reg, an_next, ad_reg, ad_next;
    word_t                 bn_reg, bn_next, bd_reg, bd_next;
    logic [EXP_BITS-2:0]   e_reg, e_next;
    logic                  ov_reg, ov_next;
    logic [1:0]            step_reg, step_next, pph_reg, pph_next;
    prod_t                 p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    word_t                 rn_reg, rn_next, rd_reg, rd_next;
    word_t                 mn_reg, mn_next, md_reg, md_next;
    uword_t                gu_reg, gu_next, gv_reg, gv_next, g_reg, g_next;
    uword_t                dq_reg, dq_next, rem_reg, rem_next;
    logic [SHIFT_BITS-1:0] gk_reg, gk_next, dcnt_reg, dcnt_next;
    logic                  dsel_reg, dsel_next;

    logic                  out_valid_reg, out_valid_next;
    logic signed [IO_BITS-1:0] res_num_reg, res_den_reg;
    logic                  eq_reg, lt_reg, gt_reg, ovf_reg, zd_reg;
    logic                  load_out;

    logic                  mul_start, mul_done;
    word_t                 mul_x, mul_y;
    prod_t                 mul_prod;
    word_t                 mul_lo;
    logic                  mul_ov;

    logic [1:0]            nsteps;
    uword_t                g_fin;
    logic [WORD_BITS:0]    rem_sh;
    logic                  div_ge;
    uword_t                rem_step, dq_step;
    logic [EXP_BITS-2:0]   e_shift;

    frac_t                 fin;
    logic                  fin_eq, fin_lt, fin_gt, fin_ov;
    word_t                 p0_lo, p1_lo, p2_lo, sum_w, red_n, red_d;

    rau_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    assign mul_lo  = word_t'(mul_prod[WORD_BITS-1:0]);
    assign mul_ov  = !fits_word(mul_prod);
    assign nsteps  = ((op_reg == OP_ADD) || (op_reg == OP_SUB)) ? 2'd3 : 2'd2;
    assign g_fin   = (gu_reg | gv_reg) << gk_reg;
    assign e_shift = e_reg >> 1;

    // one restoring divider step
    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[WORD_BITS-1]};
        div_ge   = (rem_sh >= {1'b0, g_reg});
        rem_step = div_ge ? uword_t'(rem_sh - {1'b0, g_reg}) : rem_sh[WORD_BITS-1:0];
        dq_step  = {dq_reg[WORD_BITS-2:0], div_ge};
    end

    // result assembly for the finished job
    always_comb
    begin
        p0_lo  = word_t'(p0_reg[WORD_BITS-1:0]);
        p1_lo  = word_t'(p1_reg[WORD_BITS-1:0]);
        p2_lo  = word_t'(p2_reg[WORD_BITS-1:0]);
        sum_w  = WORD_ZERO;
        red_n  = an_reg[WORD_BITS-1] ? -rn_reg : rn_reg;
        red_d  = ad_reg[WORD_BITS-1] ? -rd_reg : rd_reg;
        fin.n  = WORD_ZERO;
        fin.d  = WORD_ZERO;
        fin.ov = 1'b0;
        fin_eq = 1'b0;
        fin_lt = 1'b0;
        fin_gt = 1'b0;
        unique case (op_reg)
            OP_ADD:
            begin
                sum_w  = p0_lo + p1_lo;
                fin.n  = sum_w;
                fin.d  = p2_lo;
                fin.ov = (p0_lo[WORD_BITS-1] == p1_lo[WORD_BITS-1])
                      && (sum_w[WORD_BITS-1] != p0_lo[WORD_BITS-1]);
            end
            OP_SUB:
            begin
                sum_w  = p0_lo - p1_lo;
                fin.n  = sum_w;
                fin.d  = p2_lo;
                fin.ov = (p0_lo[WORD_BITS-1] != p1_lo[WORD_BITS-1])
                      && (sum_w[WORD_BITS-1] != p0_lo[WORD_BITS-1]);
            end
            OP_MUL:
            begin
                fin.n = p0_lo;
                fin.d = p1_lo;
            end
            OP_DIV:
            begin
                fin = norm_f(p0_lo, p1_lo);
            end
            OP_CMP:
            begin
                fin_eq = (p0_reg == p1_reg);
                fin_lt = (p0_reg < p1_reg);
                fin_gt = (p0_reg > p1_reg);
            end
            OP_RED:
            begin
                if (g_reg != '0)
                begin
                    fin = norm_f(red_n, red_d);
                end
            end
            OP_POW:
            begin
                fin.n = rn_reg;
                fin.d = rd_reg;
            end
            OP_INV:
            begin
                fin = norm_f(ad_reg, an_reg);
            end
        endcase
        fin_ov = ov_reg | fin.ov;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        an_next    = an_reg;
        ad_next    = ad_reg;
        bn_next    = bn_reg;
        bd_next    = bd_reg;
        e_next     = e_reg;
        ov_next    = ov_reg;
        step_next  = step_reg;
        pph_next   = pph_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        rn_next    = rn_reg;
        rd_next    = rd_reg;
        mn_next    = mn_reg;
        md_next    = md_reg;
        gu_next    = gu_reg;
        gv_next    = gv_reg;
        g_next     = g_reg;
        gk_next    = gk_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        dsel_next  = dsel_reg;
        q_pop      = 1'b0;
        mul_start  = 1'b0;
        mul_x      = an_reg;
        mul_y      = bd_reg;
        load_out   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    op_next   = q_job.op;
                    an_next   = q_job.an;
                    ad_next   = q_job.ad;
                    bn_next   = q_job.bn;
                    bd_next   = q_job.bd;
                    e_next    = q_job.expo;
                    ov_next   = q_job.ov;
                    step_next = '0;
                    pph_next  = '0;
                    rn_next   = WORD_ONE;
                    rd_next   = WORD_ONE;
                    mn_next   = q_job.an;
                    md_next   = q_job.ad;
                    gu_next   = mag_f(q_job.an);
                    gv_next   = mag_f(q_job.ad);
                    gk_next   = '0;
                    case (q_job.op) inside
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: state_next = ST_ARITH;
                        OP_RED:                                 state_next = ST_GCD;
                        OP_POW:                                 state_next = ST_POWER;
                        default:                                state_next = ST_FIN;
                    endcase
                end
            end

            // cross products, one at a time
            ST_ARITH:
            begin
                if (step_reg == nsteps)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MULW;
                    unique case (step_reg)
                        2'd0:
                        begin
                            mul_x = an_reg;
                            mul_y = (op_reg == OP_MUL) ? bn_reg : bd_reg;
                        end
                        2'd1:
                        begin
                            mul_x = ((op_reg == OP_MUL) || (op_reg == OP_DIV)) ? ad_reg : bn_reg;
                            mul_y = (op_reg == OP_MUL) ? bd_reg
                                  : (op_reg == OP_DIV) ? bn_reg : ad_reg;
                        end
                        default:
                        begin
                            mul_x = ad_reg;
                            mul_y = bd_reg;
                        end
                    endcase
                end
            end

            // square and multiply, lowest exponent bit first
            ST_POWER:
            begin
                unique case (pph_reg)
                    2'd0:
                    begin
                        if (e_reg == '0)
                        begin
                            state_next = ST_FIN;
                        end
                        else if (e_reg[0])
                        begin
                            mul_start  = 1'b1;
                            mul_x      = rn_reg;
                            mul_y      = mn_reg;
                            state_next = ST_MULW;
                        end
                        else
                        begin
                            pph_next = 2'd2;
                        end
                    end
                    2'd1:
                    begin
                        mul_start  = 1'b1;
                        mul_x      = rd_reg;
                        mul_y      = md_reg;
                        state_next = ST_MULW;
                    end
                    2'd2:
                    begin
                        e_next = e_shift;
                        if (e_shift == '0)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            mul_start  = 1'b1;
                            mul_x      = mn_reg;
                            mul_y      = mn_reg;
                            state_next = ST_MULW;
                        end
                    end
                    default:
                    begin
                        mul_start  = 1'b1;
                        mul_x      = md_reg;
                        mul_y      = md_reg;
                        state_next = ST_MULW;
                    end
                endcase
            end

            ST_MULW:
            begin
                if (mul_done)
                begin
                    if (op_reg == OP_POW)
                    begin
                        ov_next    = ov_reg | mul_ov;
                        pph_next   = pph_reg + 1'b1;
                        state_next = ST_POWER;
                        case (pph_reg)
                            2'd0:    rn_next = mul_lo;
                            2'd1:    rd_next = mul_lo;
                            2'd2:    mn_next = mul_lo;
                            default: md_next = mul_lo;
                        endcase
                    end
                    else
                    begin
                        if (op_reg != OP_CMP)
                        begin
                            ov_next = ov_reg | mul_ov;
                        end
                        step_next  = step_reg + 1'b1;
                        state_next = ST_ARITH;
                        case (step_reg)
                            2'd0:    p0_next = mul_prod;
                            2'd1:    p1_next = mul_prod;
                            default: p2_next = mul_prod;
                        endcase
                    end
                end
            end

            // binary gcd of the magnitudes of A
            ST_GCD:
            begin
                if ((gu_reg == '0) || (gv_reg == '0))
                begin
                    g_next = g_fin;
                    if (g_fin == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        dq_next    = mag_f(an_reg);
                        rem_next   = '0;
                        dcnt_next  = '0;
                        dsel_next  = 1'b0;
                        state_next = ST_DIV;
                    end
                end
                else if (!gu_reg[0] && !gv_reg[0])
                begin
                    gu_next = gu_reg >> 1;
                    gv_next = gv_reg >> 1;
                    gk_next = gk_reg + 1'b1;
                end
                else if (!gu_reg[0])
                begin
                    gu_next = gu_reg >> 1;
                end
                else if (!gv_reg[0])
                begin
                    gv_next = gv_reg >> 1;
                end
                else if (gu_reg >= gv_reg)
                begin
                    gu_next = (gu_reg - gv_reg) >> 1;
                end
                else
                begin
                    gv_next = (gv_reg - gu_reg) >> 1;
                end
            end

            // both magnitudes of A divided by the gcd, one bit a cycle
            ST_DIV:
            begin
                rem_next  = rem_step;
                dq_next   = dq_step;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == SHIFT_BITS'(WORD_BITS-1))
                begin
                    if (!dsel_reg)
                    begin
                        rn_next   = word_t'(dq_step);
                        dq_next   = mag_f(ad_reg);
                        rem_next  = '0;
                        dcnt_next = '0;
                        dsel_next = 1'b1;
                    end
                    else
                    begin
                        rd_next    = word_t'(dq_step);
                        state_next = ST_FIN;
                    end
                end
            end

            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // output beat valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        an_reg   <= an_next;
        ad_reg   <= ad_next;
        bn_reg   <= bn_next;
        bd_reg   <= bd_next;
        e_reg    <= e_next;
        ov_reg   <= ov_next;
        step_reg <= step_next;
        pph_reg  <= pph_next;
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        rn_reg   <= rn_next;
        rd_reg   <= rd_next;
        mn_reg   <= mn_next;
        md_reg   <= md_next;
        gu_reg   <= gu_next;
        gv_reg   <= gv_next;
        g_reg    <= g_next;
        gk_reg   <= gk_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        dcnt_reg <= dcnt_next;
        dsel_reg <= dsel_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            res_num_reg <= to_io(fin.n);
            res_den_reg <= to_io(fin.d);
            eq_reg      <= fin_eq;
            lt_reg      <= fin_lt;
            gt_reg      <= fin_gt;
            ovf_reg     <= fin_ov;
            zd_reg      <= (op_reg != OP_CMP) && (fin.d == WORD_ZERO);
        end
    end

    assign out_valid  = out_valid_reg;
    assign res_num    = res_num_reg;
    assign res_den    = res_den_reg;
    assign is_equal   = eq_reg;
    assign is_less    = lt_reg;
    assign is_greater = gt_reg;
    assign overflow   = ovf_reg;
    assign zero_den   = zd_reg;

`ifndef SYNTHESIS
    // a product only completes while the sequencer waits for it
    a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MULW))
        else $error("multiplier finished outside the wait state");

    // the divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (g_reg != '0))
        else $error("divide step with zero gcd");

    // at most one compare verdict per result beat
    a_verdict_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($countones({eq_reg, lt_reg, gt_reg}) <= 1))
        else $error("more than one compare verdict");

    // a compare verdict comes with a zero fraction and no zero-denominator flag
    a_verdict_zero_frac: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (eq_reg || lt_reg || gt_reg))
            |-> ((res_num_reg == '0) && (res_den_reg == '0) && !zd_reg))
        else $error("compare beat carries a fraction");
`endif

endmodule

// File: sv/rational_arithmetic_unit_top.sv
// Rational arithmetic unit: add, sub, mul, div, compare, reduce, power and invert on two
// signed fractions. Items pass a registered front stage (denominator sign normalization) into
// a two-entry job queue, so a new input beat is taken while the back end works or a result
// waits, as long as the queue has room. The back end runs one job at a time; its time per
// item is set by the shared half-width multiplier, which forms each exact 64x64 product from
// four partial products, and by the bit-serial gcd and divider. Add and sub take three
// products, mul, div and compare two, invert none; reduce runs binary gcd steps and then
// divide steps for both parts; power takes up to four products per exponent bit. Overflow
// wraps results to the word width and raises the overflow flag.
module rational_arithmetic_unit_top
    import rau_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic        [2:0]          action,
    input  logic signed [IO_BITS-1:0]  a_num,
    input  logic signed [IO_BITS-1:0]  a_den,
    input  logic signed [IO_BITS-1:0]  b_num,
    input  logic signed [IO_BITS-1:0]  b_den,
    input  logic signed [EXP_BITS-1:0] exponent,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [IO_BITS-1:0]  res_num,
    output logic signed [IO_BITS-1:0]  res_den,
    output logic                       is_equal,
    output logic                       is_less,
    output logic                       is_greater,
    output logic                       overflow,
    output logic                       zero_den
);

    logic push, q_full, q_valid, q_pop;
    job_t push_job, q_job;

    // front stage
    rau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .exponent (exponent),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    // job queue
    rau_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_job  (q_job)
    );

    // back end
    rau_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_job      (q_job),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .res_num    (res_num),
        .res_den    (res_den),
        .is_equal   (is_equal),
        .is_less    (is_less),
        .is_greater (is_greater),
        .overflow   (overflow),
        .zero_den   (zero_den)
    );

endmodule

// File: tb/sv/rau_checker.sv
// checker for the rational arithmetic unit: predicts each result and compares it
`timescale 1ns / 100ps

module rau_checker
    import rau_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic        [2:0]          action,
    input  logic signed [IO_BITS-1:0]  a_num,
    input  logic signed [IO_BITS-1:0]  a_den,
    input  logic signed [IO_BITS-1:0]  b_num,
    input  logic signed [IO_BITS-1:0]  b_den,
    input  logic signed [EXP_BITS-1:0] exponent,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [IO_BITS-1:0]  res_num,
    input  logic signed [IO_BITS-1:0]  res_den,
    input  logic                       is_equal,
    input  logic                       is_less,
    input  logic                       is_greater,
    input  logic                       overflow,
    input  logic                       zero_den,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic [63:0] n;
        logic [63:0] d;
        logic        eq;
        logic        lt;
        logic        gt;
        logic        ov;
        logic        zd;
    } rat_result_t;

    rat_result_t result_q[$];

    // wrapping arithmetic on 64-bit words, flagging overflow
    function automatic logic [63:0] fr_add(logic [63:0] a, logic [63:0] b, inout logic ov);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            ov = 1'b1;
        return s;
    endfunction

    function automatic logic [63:0] fr_sub(logic [63:0] a, logic [63:0] b, inout logic ov);
        logic [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63])
            ov = 1'b1;
        return s;
    endfunction

    function automatic logic signed [127:0] full_prod(logic [63:0] a, logic [63:0] b);
        logic signed [127:0] x;
        logic signed [127:0] y;
        x = {{64{a[63]}}, a};
        y = {{64{b[63]}}, b};
        return x * y;
    endfunction

    function automatic logic [63:0] fr_mul(logic [63:0] a, logic [63:0] b, inout logic ov);
        logic signed [127:0] p;
        p = full_prod(a, b);
        if (p[127:63] != {65{p[63]}})
            ov = 1'b1;
        return p[63:0];
    endfunction

    // denominator made non-negative
    function automatic void fr_norm(inout logic [63:0] n, inout logic [63:0] d,
                                    inout logic ov);
        if (d[63])
        begin
            n = fr_sub(64'd0, n, ov);
            d = fr_sub(64'd0, d, ov);
        end
    endfunction

    function automatic logic [63:0] magnitude(logic [63:0] x);
        return x[63] ? 64'd0 - x : x;
    endfunction

    function automatic logic [63:0] signed_quot(logic [63:0] x, logic [63:0] g);
        logic [63:0] q;
        q = magnitude(x) / g;
        return x[63] ? 64'd0 - q : q;
    endfunction

    function automatic rat_result_t predict_rational(logic [2:0] act, logic [63:0] an_i,
        logic [63:0] ad_i, logic [63:0] bn_i, logic [63:0] bd_i, logic [31:0] e_i);
        rat_result_t r;
        logic [63:0] an, ad, bn, bd, mn, md, g, u, v, t;
        logic signed [127:0] p1, p2;
        logic ov;
        logic [31:0] e;
        an = an_i; ad = ad_i; bn = bn_i; bd = bd_i; e = e_i;
        r = '0;
        ov = 1'b0;
        fr_norm(an, ad, ov);
        fr_norm(bn, bd, ov);
        case (op_t'(act))
            OP_ADD:
            begin
                r.n = fr_add(fr_mul(an, bd, ov), fr_mul(bn, ad, ov), ov);
                r.d = fr_mul(ad, bd, ov);
            end
            OP_SUB:
            begin
                r.n = fr_sub(fr_mul(an, bd, ov), fr_mul(bn, ad, ov), ov);
                r.d = fr_mul(ad, bd, ov);
            end
            OP_MUL:
            begin
                r.n = fr_mul(an, bn, ov);
                r.d = fr_mul(ad, bd, ov);
            end
            OP_DIV:
            begin
                r.n = fr_mul(an, bd, ov);
                r.d = fr_mul(ad, bn, ov);
                fr_norm(r.n, r.d, ov);
            end
            OP_CMP:
            begin
                p1 = full_prod(an, bd);
                p2 = full_prod(bn, ad);
                r.eq = (p1 == p2);
                r.lt = (p1 < p2);
                r.gt = (p1 > p2);
            end
            OP_RED:
            begin
                u = magnitude(an);
                v = magnitude(ad);
                while (v != 0)
                begin
                    t = u % v;
                    u = v;
                    v = t;
                end
                g = u;
                if (g != 0)
                begin
                    r.n = signed_quot(an, g);
                    r.d = signed_quot(ad, g);
                    fr_norm(r.n, r.d, ov);
                end
            end
            OP_POW:
            begin
                mn = an; md = ad;
                r.n = 64'd1; r.d = 64'd1;
                if (e[31])
                    e = 0;
                while (e > 0)
                begin
                    if (e[0])
                    begin
                        r.n = fr_mul(r.n, mn, ov);
                        r.d = fr_mul(r.d, md, ov);
                    end
                    e = e >> 1;
                    if (e > 0)
                    begin
                        mn = fr_mul(mn, mn, ov);
                        md = fr_mul(md, md, ov);
                    end
                end
            end
            default:
            begin
                r.n = ad;
                r.d = an;
                fr_norm(r.n, r.d, ov);
            end
        endcase
        r.ov = ov;
        r.zd = (op_t'(act) != OP_CMP) && (r.d == 0);
        return r;
    endfunction

    // collect input beats and compare output beats
    always @(posedge clk or negedge rst_n)
    begin
        rat_result_t want;
        if (!rst_n)
        begin
            result_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                result_q.push_back(predict_rational(action, a_num, a_den, b_num, b_den,
                                                    exponent));
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("unexpected result beat");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (res_num !== want.n || res_den !== want.d || is_equal !== want.eq
                        || is_less !== want.lt || is_greater !== want.gt
                        || overflow !== want.ov || zero_den !== want.zd)
                    begin
                        fail_count <= fail_count + 1;
                        if (res_num !== want.n)
                            $error("res_num exp %h got %h", want.n, res_num);
                        if (res_den !== want.d)
                            $error("res_den exp %h got %h", want.d, res_den);
                        if (is_equal !== want.eq)
                            $error("is_equal exp %b got %b", want.eq, is_equal);
                        if (is_less !== want.lt)
                            $error("is_less exp %b got %b", want.lt, is_less);
                        if (is_greater !== want.gt)
                            $error("is_greater exp %b got %b", want.gt, is_greater);
                        if (overflow !== want.ov)
                            $error("overflow exp %b got %b", want.ov, overflow);
                        if (zero_den !== want.zd)
                            $error("zero_den exp %b got %b", want.zd, zero_den);
                    end
                end
            end
            pending <= result_q.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
// testbench top for the rational arithmetic unit: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb;
    import rau_pkg::*;

    localparam int RANDOM_BEATS = 800;
    localparam int CYCLE_LIMIT  = 5000000;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic        [2:0]          action;
    logic signed [IO_BITS-1:0]  a_num;
    logic signed [IO_BITS-1:0]  a_den;
    logic signed [IO_BITS-1:0]  b_num;
    logic signed [IO_BITS-1:0]  b_den;
    logic signed [EXP_BITS-1:0] exponent;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [IO_BITS-1:0]  res_num;
    logic signed [IO_BITS-1:0]  res_den;
    logic                       is_equal;
    logic                       is_less;
    logic                       is_greater;
    logic                       overflow;
    logic                       zero_den;
    int                         fail_count;
    int                         pending;
    int                         cycle_count = 0;

    rational_arithmetic_unit_top i_dut (.*);

    rau_checker i_checker (.*);

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // run-time limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // random 64-bit operand word, biased to small and corner values
    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return 64'd0;
            3, 4: return {$urandom, $urandom};
            5: return {{48{1'b1}}, 16'($urandom)};
            default: return 64'($signed(8'($urandom)));
        endcase
    endfunction

    function automatic logic [31:0] pick_exp();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7fff_ffff;
            default: return 32'($signed(5'($urandom)));
        endcase
    endfunction

    // offer one beat and wait until it is taken
    task automatic send_beat(op_t op, logic [63:0] an, logic [63:0] ad, logic [63:0] bn,
                             logic [63:0] bd, logic [31:0] e);
        action   <= op;
        a_num    <= an;
        a_den    <= ad;
        b_num    <= bn;
        b_den    <= bd;
        exponent <= e;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver stall pattern, with one long hold-off
    initial
    begin
        int hold;
        out_stall = 1'b0;
        wait (rst_n);
        repeat (40)
            @(negedge clk);
        out_stall <= 1'b1;
        for (hold = 0; hold < 3000; hold++)
            @(negedge clk);
        forever
        begin
            @(negedge clk);
            case ($urandom_range(0, 3))
                0: out_stall <= 1'b1;
                1: out_stall <= ($urandom_range(0, 7) == 0);
                default: out_stall <= 1'b0;
            endcase
        end
    end

    // stimulus and verdict
    initial
    begin
        int i;
        int op_i;
        int gap;
        int burst;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = '0;
        a_num = '0;
        a_den = '0;
        b_num = '0;
        b_den = '0;
        exponent = '0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed corners, every operation
        for (op_i = 0; op_i < 8; op_i++)
            send_beat(op_t'(op_i), 64'd3, -64'sd4, -64'sd5, 64'd6, 32'd3);
        send_beat(OP_ADD, WORD_MIN, 64'h7fff_ffff_ffff_ffff, WORD_MIN, WORD_MIN, 32'd0);
        send_beat(OP_MUL, 64'h7fff_ffff_ffff_ffff, WORD_MIN, WORD_MIN, -64'sd1, 32'd0);
        send_beat(OP_DIV, 64'd7, 64'd3, 64'd0, 64'd5, 32'd0);
        send_beat(OP_CMP, WORD_MIN, 64'd1, WORD_MIN, WORD_MIN, 32'd0);
        send_beat(OP_CMP, -64'sd2, 64'd4, -64'sd1, 64'd2, 32'd0);
        send_beat(OP_RED, 64'd0, 64'd0, 64'd0, 64'd0, 32'd0);
        send_beat(OP_RED, 64'd12, WORD_MIN, 64'd0, 64'd0, 32'd0);
        send_beat(OP_RED, -64'sd36, -64'sd48, 64'd0, 64'd0, 32'd0);
        send_beat(OP_POW, 64'd3, 64'd2, 64'd0, 64'd0, 32'h8000_0000);
        send_beat(OP_POW, 64'd3, 64'd2, 64'd0, 64'd0, 32'h7fff_ffff);
        send_beat(OP_POW, 64'd2, 64'd1, 64'd0, 64'd0, 32'd63);
        send_beat(OP_POW, -64'sd3, 64'd5, 64'd0, 64'd0, 32'd0);
        send_beat(OP_INV, 64'd0, 64'd5, 64'd0, 64'd0, 32'd0);
        send_beat(OP_INV, WORD_MIN, 64'd1, 64'd0, 64'd0, 32'd0);
        send_beat(OP_INV, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, {64{1'b1}},
                  {64{1'b1}}, 32'hffff_ffff);

        // random bursts and gaps
        i = 0;
        while (i < RANDOM_BEATS)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && i < RANDOM_BEATS)
            begin
                send_beat(op_t'($urandom_range(0, 7)), pick_word(), pick_word(), pick_word(),
                          pick_word(), pick_exp());
                burst--;
                i++;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap)
                    @(negedge clk);
            end
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (1000)
            @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
